### sv/byte_word_memory_access_unit_top_defines.svh
// assertion macros for the byte/word memory access unit
// expects signals named clock and reset in the including scope
`ifndef BYTE_WORD_MEMORY_ACCESS_UNIT_TOP_DEFINES_SVH
`define BYTE_WORD_MEMORY_ACCESS_UNIT_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BWM_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// implication checked a fixed number of cycles later
`define BWM_ASSERT_LATER(label, ante, dly, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> ##dly (cons)) \
      else $error(msg);

`endif

### sv/bwm_pkg.sv
// shared types and constants for the byte/word memory access unit
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package bwm_pkg;

   // store geometry: words of two byte lanes, power-of-two depth
   localparam int MEM_WORDS = 32768;
   localparam int WORD_AW   = $clog2(MEM_WORDS);
   localparam int BYTE_W    = 8;
   localparam int DATA_W    = 2 * BYTE_W;
   localparam int ADDR_W    = 16;
   localparam int OP_W      = 2;

   // access codes
   localparam logic [OP_W-1:0] OP_BYTE_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_BYTE_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_WORD_READ  = 2'd2;
   localparam logic [OP_W-1:0] OP_WORD_WRITE = 2'd3;

   typedef logic [WORD_AW-1:0] word_index_type;
   typedef logic [BYTE_W-1:0]  byte_type;

   // controller to datapath commands
   typedef struct packed {
      logic clear;    // zero one word of both banks during the clearing pass
      logic access;   // drive both banks with the accepted word
      logic load;     // capture the result into the output register
   } bwm_cmd_type;

endpackage

`default_nettype wire

### sv/bwm_req_if.sv
// request channel: access code, byte address and write data
// depends on bwm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bwm_req_if
   import bwm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [OP_W-1:0]   op;
   logic [ADDR_W-1:0] byte_address;
   logic [DATA_W-1:0] write_data;

   modport source (output valid, output op, output byte_address, output write_data,
                   input ready);
   modport sink   (input valid, input op, input byte_address, input write_data,
                   output ready);
endinterface

`default_nettype wire

### sv/bwm_rsp_if.sv
// response channel: read data
// depends on bwm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface bwm_rsp_if
   import bwm_pkg::*;
   ();
   logic              valid;
   logic              ready;
   logic [DATA_W-1:0] read_data;

   modport source (output valid, output read_data, input ready);
   modport sink   (input valid, input read_data, output ready);
endinterface

`default_nettype wire

### sv/bwm_ctrl.sv
// controller: request/response handshake and access sequencing
// depends on bwm_pkg
`timescale 1ns / 1ps
`default_nettype none

module bwm_ctrl
   import bwm_pkg::*;
   (
   input  wire logic  clock,
   input  wire logic  reset,
   input  wire logic  req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  wire logic  rsp_ready,
   input  wire logic  clear_last,
   output bwm_cmd_type cmd
   );

   localparam logic [1:0] S_CLEAR = 2'd0;
   localparam logic [1:0] S_IDLE  = 2'd1;
   localparam logic [1:0] S_READ  = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   // take a word only when idle and the output register is free by next cycle
   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;

   assign cmd.clear  = (state_ff == S_CLEAR);
   assign cmd.access = accept;
   assign cmd.load   = (state_ff == S_READ);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clear_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (accept) state_in = S_READ;
         end
         S_READ: begin
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // output word valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

### sv/bwm_datapath.sv
// datapath: low and high byte banks, lane steering and result register
// depends on bwm_pkg
`timescale 1ns / 1ps
`default_nettype none

module bwm_datapath
   import bwm_pkg::*;
   (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire bwm_cmd_type       cmd,
   input  wire logic [OP_W-1:0]   op,
   input  wire logic [ADDR_W-1:0] byte_address,
   input  wire logic [DATA_W-1:0] write_data,
   output logic                   clear_last,
   output logic [DATA_W-1:0]      read_data
   );

   // byte lanes: low bank holds even bytes, high bank holds odd bytes
   byte_type lo_bank_ff [MEM_WORDS];
   byte_type hi_bank_ff [MEM_WORDS];

   word_index_type    word_idx, next_idx, lo_addr;
   word_index_type    clear_idx_ff, clear_idx_in;
   word_index_type    lo_port, hi_port;
   logic              odd, is_word;
   logic              lo_we, hi_we;
   logic              lo_wr, hi_wr;
   byte_type          lo_wdata, hi_wdata;
   byte_type          lo_wr_data, hi_wr_data;
   byte_type          lo_rd_ff, hi_rd_ff;
   logic [OP_W-1:0]   op_ff;
   logic              odd_ff;
   logic [DATA_W-1:0] result;
   logic [DATA_W-1:0] rsp_data_ff;

   // address split; the next word wraps through the index width
   assign odd      = byte_address[0];
   assign word_idx = byte_address[WORD_AW:1];
   assign next_idx = word_index_type'(word_idx + 1'b1);
   assign is_word  = (op == OP_WORD_READ) || (op == OP_WORD_WRITE);
   assign lo_addr  = (odd && is_word) ? next_idx : word_idx;

   // lane write enables and data
   always_comb begin
      lo_we    = 1'b0;
      hi_we    = 1'b0;
      lo_wdata = write_data[BYTE_W-1:0];
      hi_wdata = write_data[BYTE_W-1:0];
      case (op)
         OP_BYTE_WRITE: begin
            lo_we = !odd;
            hi_we = odd;
         end
         OP_WORD_WRITE: begin
            lo_we = 1'b1;
            hi_we = 1'b1;
            if (odd) begin
               lo_wdata = write_data[DATA_W-1:BYTE_W];
            end else begin
               hi_wdata = write_data[DATA_W-1:BYTE_W];
            end
         end
         default: begin
            lo_we = 1'b0;
            hi_we = 1'b0;
         end
      endcase
   end

   // clearing pass after reset walks every word once
   assign clear_idx_in = word_index_type'(clear_idx_ff + 1'b1);
   assign clear_last   = &clear_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clear_idx_ff <= '0;
      end else if (cmd.clear) begin
         clear_idx_ff <= clear_idx_in;
      end
   end

   // bank ports shared by the clearing pass and the accepted word
   assign lo_port    = cmd.clear ? clear_idx_ff : lo_addr;
   assign hi_port    = cmd.clear ? clear_idx_ff : word_idx;
   assign lo_wr      = cmd.clear || (cmd.access && lo_we);
   assign hi_wr      = cmd.clear || (cmd.access && hi_we);
   assign lo_wr_data = cmd.clear ? '0 : lo_wdata;
   assign hi_wr_data = cmd.clear ? '0 : hi_wdata;

   // low bank port
   always_ff @(posedge clock) begin
      if (lo_wr) lo_bank_ff[lo_port] <= lo_wr_data;
      if (cmd.access) lo_rd_ff <= lo_bank_ff[lo_port];
   end

   // high bank port
   always_ff @(posedge clock) begin
      if (hi_wr) hi_bank_ff[hi_port] <= hi_wr_data;
      if (cmd.access) hi_rd_ff <= hi_bank_ff[hi_port];
   end

   // access attributes kept for the result stage
   always_ff @(posedge clock) begin
      if (cmd.access) begin
         op_ff  <= op;
         odd_ff <= odd;
      end
   end

   // result assembly: zero-extended byte, aligned or spanning word, zero for writes
   always_comb begin
      case (op_ff)
         OP_BYTE_READ: result = {{BYTE_W{1'b0}}, odd_ff ? hi_rd_ff : lo_rd_ff};
         OP_WORD_READ: result = odd_ff ? {lo_rd_ff, hi_rd_ff} : {hi_rd_ff, lo_rd_ff};
         default:      result = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.load) rsp_data_ff <= result;
   end

   assign read_data = rsp_data_ff;

endmodule

`default_nettype wire

### sv/byte_word_memory_access_unit_top.sv
// top level of the byte/word memory access unit
// depends on bwm_pkg, bwm_req_if, bwm_rsp_if, bwm_ctrl, bwm_datapath
`timescale 1ns / 1ps
`default_nettype none
`include "byte_word_memory_access_unit_top_defines.svh"

// Byte-addressed little-endian data memory of 16-bit words. Each request word
// is one byte read, byte write, word read or word write; each gives exactly one
// response word (zero for writes, zero-extended byte for byte reads). A word
// access at an odd address takes the high byte of word w and the low byte of
// word w+1, wrapping to word 0 at the top. Storage is two byte-wide banks, so
// every access, aligned or not, is one port operation per bank. An accepted
// item first has its bank read registered, then the output register is loaded
// from it; no new request is taken while the bank read is in flight, nor while
// a response is stalled. After reset the store is zeroed one word per cycle,
// all MEM_WORDS (32768) words, and no request is taken until that pass ends; a
// half never written reads as zero.
module byte_word_memory_access_unit_top
   import bwm_pkg::*;
   (
   input  wire logic clock,
   input  wire logic reset,
   bwm_req_if.sink   req_chan,
   bwm_rsp_if.source rsp_chan
   );

   bwm_cmd_type cmd;
   logic        clear_last;

   bwm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_chan.valid),
      .req_ready  (req_chan.ready),
      .rsp_valid  (rsp_chan.valid),
      .rsp_ready  (rsp_chan.ready),
      .clear_last (clear_last),
      .cmd        (cmd)
   );

   bwm_datapath u_datapath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .op           (req_chan.op),
      .byte_address (req_chan.byte_address),
      .write_data   (req_chan.write_data),
      .clear_last   (clear_last),
      .read_data    (rsp_chan.read_data)
   );

   // an accepted word yields a response after the bank read and the output register load
   `BWM_ASSERT_LATER(a_rsp_after_req, req_chan.valid && req_chan.ready, 2, rsp_chan.valid,
                     "response missing two cycles after accept")

   // no back-to-back accepts while the bank read is in flight
   `BWM_ASSERT_LATER(a_busy_after_req, req_chan.valid && req_chan.ready, 1, !req_chan.ready,
                     "request accepted during access")

   // a stalled response blocks new requests
   `BWM_ASSERT_NOW(a_stall_blocks_req, rsp_chan.valid && !rsp_chan.ready, !req_chan.ready,
                   "request taken while response stalled")

endmodule

`default_nettype wire
